>>> rtl/core/fpha_pkg.sv
`default_nettype none

package fpha_pkg;

  // list geometry and field widths
  localparam int MaxHoles = 64;
  localparam int SizeW    = 9;
  localparam int OffW     = 32;
  localparam int LenW     = 8;
  localparam int ModeW    = 2;

  // bytes added to every record for its length prefix
  localparam logic [SizeW-1:0] PrefixBytes = SizeW'(4);

  // fit modes
  localparam logic [ModeW-1:0] FitFirst = 2'd0;
  localparam logic [ModeW-1:0] FitBest  = 2'd1;
  localparam logic [ModeW-1:0] FitWorst = 2'd2;

  // request codes
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    StatPlaced   = 2'd0,
    StatAppended = 2'd1,
    StatRecorded = 2'd2,
    StatDropped  = 2'd3
  } status_e;

  typedef struct packed {
    logic            op;
    logic [LenW-1:0] record_length;
    logic [OffW-1:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [OffW-1:0] offset;
    status_e         status;
  } rsp_t;

  // one list entry as held by a cell
  typedef struct packed {
    logic             valid;
    logic [SizeW-1:0] size;
    logic [OffW-1:0]  off;
  } hole_t;

  // what every cell does in a cycle
  typedef enum logic [2:0] {
    CellHold    = 3'd0,
    CellCapture = 3'd1,
    CellRemove  = 3'd2,
    CellInsert  = 3'd3,
    CellSwap    = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [SizeW-1:0] key_size;
    logic [OffW-1:0]  key_off;
    logic             descending;
    logic             sorted;
    logic             front_only;
    logic             phase;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/fpha_cell.sv
`default_nettype none

module fpha_cell import fpha_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       first_i,
  input  wire logic       odd_i,
  input  wire hole_t      left_i,
  input  wire hole_t      right_i,
  input  wire logic       ins_left_i,
  input  wire logic       take_left_i,
  output hole_t           hole_o,
  output logic            match_o,
  output logic            ins_o,
  output logic            take_o
);

  logic             valid_q, valid_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [OffW-1:0]  off_q, off_d;
  logic             match_q, match_d;
  logic             is_left;
  logic             swap_right;
  logic             swap_left;

  assign hole_o  = '{valid: valid_q, size: size_q, off: off_q};
  assign match_o = match_q;

  // insertion point: first empty slot, or first entry ordered after the key
  assign ins_o = !valid_q ||
                 (ctrl_i.sorted && (ctrl_i.descending ? (size_q < ctrl_i.key_size)
                                                      : (size_q > ctrl_i.key_size)));

  // from the chosen hole on, entries close up toward the front
  assign take_o = match_q | take_left_i;

  // odd-even transposition pairs, strict compare keeps equal sizes in order
  assign is_left    = (odd_i == ctrl_i.phase);
  assign swap_right = valid_q && right_i.valid &&
                      (ctrl_i.descending ? (size_q < right_i.size) : (size_q > right_i.size));
  assign swap_left  = left_i.valid && valid_q &&
                      (ctrl_i.descending ? (left_i.size < size_q) : (left_i.size > size_q));

  // next entry and match flag
  always_comb begin
    valid_d = valid_q;
    size_d  = size_q;
    off_d   = off_q;
    match_d = match_q;
    case (ctrl_i.op)
      CellCapture: begin
        match_d = valid_q && (size_q >= ctrl_i.key_size) && (!ctrl_i.front_only || first_i);
      end
      CellRemove: begin
        if (take_o) begin
          valid_d = right_i.valid;
          size_d  = right_i.size;
          off_d   = right_i.off;
        end
      end
      CellInsert: begin
        if (ins_o && !ins_left_i) begin
          valid_d = 1'b1;
          size_d  = ctrl_i.key_size;
          off_d   = ctrl_i.key_off;
        end else if (ins_o) begin
          valid_d = left_i.valid;
          size_d  = left_i.size;
          off_d   = left_i.off;
        end
      end
      CellSwap: begin
        if (is_left && swap_right) begin
          valid_d = right_i.valid;
          size_d  = right_i.size;
          off_d   = right_i.off;
        end else if (!is_left && swap_left) begin
          valid_d = left_i.valid;
          size_d  = left_i.size;
          off_d   = left_i.off;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    off_q  <= off_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/fit_policy_hole_allocator.sv
// A result is produced in the update or insert state after its request is accepted,
// into the output register or the holding slot; new requests wait for idle.
// A free passes the insert state, an append at end of store the update state, and a
// placement in a hole both (search, remove, reinsert in the cell row). In best or
// worst fit, the first list change after a fit mode write adds an odd-even sort.
// Reset: hole list empty, first fit, end of store at zero; no clearing pass.
`default_nettype none

module fit_policy_hole_allocator import fpha_pkg::*; #(
  parameter int MAX_HOLES = MaxHoles
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire req_t             in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rsp_t                  out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [ModeW-1:0] cfg_data_i
);

  localparam int CntW = (MAX_HOLES > 2) ? $clog2(MAX_HOLES) : 1;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StUpdate = 4'b0010,
    StInsert = 4'b0100,
    StSort   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [ModeW-1:0] mode_q;
  logic             need_sort_q, need_sort_d;
  logic [OffW-1:0]  eos_q, eos_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             op_q;
  logic [SizeW-1:0] need_q;
  logic [OffW-1:0]  foff_q;
  logic [SizeW-1:0] hs_q;
  logic [OffW-1:0]  ho_q;

  logic             out_valid_q, res_valid_q;
  rsp_t             out_q, res_q;

  cell_ctrl_t       ctrl;
  hole_t            hole_w  [MAX_HOLES];
  logic [MAX_HOLES-1:0] match_w, ins_w, take_w, pick_w;
  hole_t            chosen;

  logic             in_acc;
  logic             sort_mode;
  logic             found;
  logic             full;
  logic             leftover;
  logic             ins_en;
  logic [SizeW-1:0] need_in;
  logic             produce;
  rsp_t             produce_data;

  // mode writes wait until the row has finished any update or sort
  assign cfg_ready_o = (state_q == StIdle);
  assign in_ready_o  = (state_q == StIdle) && !res_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign need_in   = {1'b0, in_data_i.record_length} + PrefixBytes;
  assign sort_mode = (mode_q == FitBest) || (mode_q == FitWorst);
  assign found     = |match_w;
  assign full      = hole_w[MAX_HOLES-1].valid;
  assign leftover  = hs_q > need_q;
  assign ins_en    = (op_q == OpFree) ? !full : leftover;

  // row of cells, each talking to its neighbors only
  for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
    hole_t left_h, right_h;
    logic  ins_l, take_l;
    if (i == 0) begin : g_head
      assign left_h = '0;
      assign ins_l  = 1'b0;
      assign take_l = 1'b0;
    end else begin : g_body
      assign left_h = hole_w[i-1];
      assign ins_l  = ins_w[i-1];
      assign take_l = take_w[i-1];
    end
    if (i == MAX_HOLES - 1) begin : g_tail
      assign right_h = '0;
    end else begin : g_next
      assign right_h = hole_w[i+1];
    end
    assign pick_w[i] = match_w[i] && !take_l;

    fpha_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .first_i     (i == 0),
      .odd_i       (i % 2 == 1),
      .left_i      (left_h),
      .right_i     (right_h),
      .ins_left_i  (ins_l),
      .take_left_i (take_l),
      .hole_o      (hole_w[i]),
      .match_o     (match_w[i]),
      .ins_o       (ins_w[i]),
      .take_o      (take_w[i])
    );
  end

  // chosen hole: and-or over the one-hot first match
  always_comb begin
    chosen = '0;
    for (int i = 0; i < MAX_HOLES; i++) begin
      chosen = chosen | (pick_w[i] ? hole_w[i] : '0);
    end
  end

  // sequencer
  always_comb begin
    state_d             = state_q;
    need_sort_d         = need_sort_q;
    eos_d               = eos_q;
    cnt_d               = cnt_q;
    produce             = 1'b0;
    produce_data        = '{offset: '0, status: StatPlaced};
    ctrl                = '0;
    ctrl.op             = CellHold;
    ctrl.descending     = (mode_q == FitWorst);
    ctrl.sorted         = sort_mode && !need_sort_q;
    ctrl.front_only     = (mode_q == FitWorst);
    ctrl.phase          = cnt_q[0];
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          ctrl.op       = CellCapture;
          ctrl.key_size = need_in;
          state_d       = (in_data_i.op == OpFree) ? StInsert : StUpdate;
        end
      end
      StUpdate: begin
        produce = 1'b1;
        if (found) begin
          ctrl.op      = CellRemove;
          produce_data = '{offset: chosen.off, status: StatPlaced};
          state_d      = StInsert;
        end else begin
          produce_data = '{offset: eos_q, status: StatAppended};
          eos_d        = eos_q + {{(OffW-SizeW){1'b0}}, need_q};
          state_d      = StIdle;
        end
      end
      StInsert: begin
        if (op_q == OpFree) begin
          produce       = 1'b1;
          produce_data  = '{offset: foff_q, status: full ? StatDropped : StatRecorded};
          ctrl.key_size = need_q;
          ctrl.key_off  = foff_q;
        end else begin
          ctrl.key_size = hs_q - need_q;
          ctrl.key_off  = ho_q + {{(OffW-SizeW){1'b0}}, need_q};
        end
        if (ins_en) begin
          ctrl.op = CellInsert;
        end
        // list changed with a stale order: sort the whole row
        if (((op_q == OpAlloc) || !full) && sort_mode && need_sort_q) begin
          cnt_d   = '0;
          state_d = StSort;
        end else begin
          state_d = StIdle;
        end
      end
      StSort: begin
        ctrl.op = CellSwap;
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == CntW'(MAX_HOLES - 1)) begin
          need_sort_d = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (cfg_valid_i && cfg_ready_o) begin
      need_sort_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= FitFirst;
      need_sort_q <= 1'b0;
      eos_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      need_sort_q <= need_sort_d;
      eos_q       <= eos_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  // request and chosen hole registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= in_data_i.op;
      need_q <= need_in;
      foff_q <= in_data_i.free_offset;
    end
    if (state_q == StUpdate) begin
      hs_q <= chosen.size;
      ho_q <= chosen.off;
    end
  end

  // output register with a one-beat holding slot behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (produce) begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_q <= 1'b1;
        end else begin
          res_valid_q <= 1'b1;
        end
      end else if (!out_valid_q || out_ready_i) begin
        out_valid_q <= res_valid_q;
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      if (!out_valid_q || out_ready_i) begin
        out_q <= produce_data;
      end else begin
        res_q <= produce_data;
      end
    end else if ((!out_valid_q || out_ready_i) && res_valid_q) begin
      out_q <= res_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fpha_checker.sv
`default_nettype none

module fpha_checker import fpha_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire rsp_t out_data_o
);

  logic [1:0] pending_q;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  // requests taken whose result beat has not gone out yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // no result beat without a request behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result beat without a pending request");

  // at most one finished result waits when a new request is taken
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> pending_q <= 2'd1)
    else $error("request taken with two results outstanding");

  // one result per request: the count never runs past two
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("outstanding request count overran");

endmodule

bind fit_policy_hole_allocator fpha_checker u_fpha_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
